// File: sv/rv32m_multiply_divide_defines.svh
// ----------------------------------------------------------------------------
// rv32m_multiply_divide_defines
// Assertion macros shared by the multiply-divide RTL.
// ----------------------------------------------------------------------------
`ifndef RV32M_MULTIPLY_DIVIDE_DEFINES_SVH
`define RV32M_MULTIPLY_DIVIDE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define RVM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Signal carries no X or Z outside reset.
`define RVM_ASSERT_KNOWN(lbl, sig, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error(msg);

`endif

// File: sv/rvm_pkg.sv
// ----------------------------------------------------------------------------
// rvm_pkg
// Operation codes, widths and the stage payload of the multiply-divide unit.
// ----------------------------------------------------------------------------
package rvm_pkg;

    localparam int DATA_BITS = 32;
    localparam int OP_BITS   = 3;
    localparam int TAG_BITS  = 6;

    localparam logic [OP_BITS-1:0] OP_MUL    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_MULH   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_MULHSU = 3'd2;
    localparam logic [OP_BITS-1:0] OP_MULHU  = 3'd3;
    localparam logic [OP_BITS-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_BITS-1:0] OP_DIVU   = 3'd5;
    localparam logic [OP_BITS-1:0] OP_REM    = 3'd6;
    localparam logic [OP_BITS-1:0] OP_REMU   = 3'd7;

    typedef struct packed {
        logic [OP_BITS-1:0]     op;
        logic                   is_div;
        logic                   neg_q;      // negate product or quotient
        logic                   neg_r;
        logic                   force_ones; // divide by zero quotient
        logic [DATA_BITS-1:0]   rem;
        logic [DATA_BITS-1:0]   quo;
        logic [DATA_BITS-1:0]   dvs;
        logic [2*DATA_BITS-1:0] prod;
    } stage_t;

endpackage

// File: sv/rvm_pre.sv
// ----------------------------------------------------------------------------
// rvm_pre
// Decode stage: operand signs, magnitudes and special-case flags.
// ----------------------------------------------------------------------------
module rvm_pre #(
    parameter int TagBits = rvm_pkg::TAG_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rvm_pkg::OP_BITS-1:0]     in_op,
    input  logic [rvm_pkg::DATA_BITS-1:0]   in_a,
    input  logic [rvm_pkg::DATA_BITS-1:0]   in_b,
    input  logic [TagBits-1:0]              in_tag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rvm_pkg::stage_t                 out_data,
    output logic [TagBits-1:0]              out_tag
);

    localparam int W = rvm_pkg::DATA_BITS;

    logic            valid_reg;
    logic            valid_next;
    rvm_pkg::stage_t data_reg;
    rvm_pkg::stage_t data_next;
    logic [TagBits-1:0] tag_reg;
    logic            sa;
    logic            sb;
    logic            na;
    logic            nb;
    logic            div_op;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        div_op = in_op[2];
        sa = (in_op == rvm_pkg::OP_MULH) || (in_op == rvm_pkg::OP_MULHSU) ||
             (in_op == rvm_pkg::OP_DIV) || (in_op == rvm_pkg::OP_REM);
        sb = (in_op == rvm_pkg::OP_MULH) || (in_op == rvm_pkg::OP_DIV) ||
             (in_op == rvm_pkg::OP_REM);
        na = sa && in_a[W-1];
        nb = sb && in_b[W-1];
        data_next.op         = in_op;
        data_next.is_div     = div_op;
        data_next.neg_q      = na ^ nb;
        data_next.neg_r      = na;
        data_next.force_ones = div_op && (in_b == '0);
        data_next.rem        = '0;
        data_next.quo        = na ? (W'(0) - in_a) : in_a;
        data_next.dvs        = nb ? (W'(0) - in_b) : in_b;
        data_next.prod       = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            tag_reg  <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_tag   = tag_reg;

endmodule

// File: sv/rvm_stage.sv
// ----------------------------------------------------------------------------
// rvm_stage
// One pipeline stage: a restoring divide step, plus a multiply step in the
// first three stages (partial products, sum, sign fix).
// ----------------------------------------------------------------------------
module rvm_stage #(
    parameter int Idx     = 1,
    parameter int TagBits = rvm_pkg::TAG_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rvm_pkg::stage_t     in_data,
    input  logic [TagBits-1:0]  in_tag,
    output logic                out_valid,
    input  logic                out_ready,
    output rvm_pkg::stage_t     out_data,
    output logic [TagBits-1:0]  out_tag
);

    localparam int W = rvm_pkg::DATA_BITS;
    localparam int H = W / 2;

    logic            valid_reg;
    logic            valid_next;
    rvm_pkg::stage_t data_reg;
    rvm_pkg::stage_t data_next;
    logic [TagBits-1:0] tag_reg;
    logic [W:0]      trial;
    logic [W:0]      diff;
    logic [W-1:0]    pp_ll;
    logic [W-1:0]    pp_lh;
    logic [W-1:0]    pp_hl;
    logic [W-1:0]    pp_hh;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        data_next = in_data;
        trial = {in_data.rem, in_data.quo[W-1]};
        diff  = trial - {1'b0, in_data.dvs};
        pp_ll = in_data.quo[H-1:0] * in_data.dvs[H-1:0];
        pp_lh = in_data.quo[H-1:0] * in_data.dvs[W-1:H];
        pp_hl = in_data.quo[W-1:H] * in_data.dvs[H-1:0];
        pp_hh = in_data.quo[W-1:H] * in_data.dvs[W-1:H];
        if (in_data.is_div)
        begin
            if (!diff[W])
            begin
                data_next.rem = diff[W-1:0];
                data_next.quo = {in_data.quo[W-2:0], 1'b1};
            end
            else
            begin
                data_next.rem = trial[W-1:0];
                data_next.quo = {in_data.quo[W-2:0], 1'b0};
            end
        end
        else if (Idx == 1)
        begin
            data_next.prod = {pp_hh, pp_ll};
            data_next.rem  = pp_lh;
            data_next.quo  = pp_hl;
        end
        else if (Idx == 2)
        begin
            data_next.prod = in_data.prod
                           + {{H{1'b0}}, in_data.rem, {H{1'b0}}}
                           + {{H{1'b0}}, in_data.quo, {H{1'b0}}};
        end
        else if (Idx == 3)
        begin
            data_next.prod = in_data.neg_q ? ((2*W)'(0) - in_data.prod) : in_data.prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
            tag_reg  <= in_tag;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_tag   = tag_reg;

endmodule

// File: sv/rvm_post.sv
// ----------------------------------------------------------------------------
// rvm_post
// Output stage: result select, quotient and remainder sign fix.
// ----------------------------------------------------------------------------
module rvm_post #(
    parameter int TagBits = rvm_pkg::TAG_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  rvm_pkg::stage_t                 in_data,
    input  logic [TagBits-1:0]              in_tag,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rvm_pkg::DATA_BITS-1:0]   out_result,
    output logic [TagBits-1:0]              out_tag
);

    localparam int W = rvm_pkg::DATA_BITS;

    logic               valid_reg;
    logic               valid_next;
    logic [W-1:0]       result_reg;
    logic [W-1:0]       result_next;
    logic [TagBits-1:0] tag_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_comb
    begin
        unique case (in_data.op)
            rvm_pkg::OP_MUL:
                result_next = in_data.prod[W-1:0];
            rvm_pkg::OP_MULH, rvm_pkg::OP_MULHSU, rvm_pkg::OP_MULHU:
                result_next = in_data.prod[2*W-1:W];
            rvm_pkg::OP_DIV, rvm_pkg::OP_DIVU:
                result_next = in_data.force_ones ? {W{1'b1}} :
                              (in_data.neg_q ? (W'(0) - in_data.quo) : in_data.quo);
            default:
                result_next = in_data.neg_r ? (W'(0) - in_data.rem) : in_data.rem;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            result_reg <= result_next;
            tag_reg    <= in_tag;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;
    assign out_tag    = tag_reg;

endmodule

// File: sv/rv32m_multiply_divide.sv
// Stages: decode, 32 divide steps, output; each stage is registered.
// Throughput: one request per cycle for every operation mix while the output is not stalled.
// Multiplies finish in the first three steps and ride the remaining stages.
// Each stage stalls on its own; bubbles fill while the output waits.
// Reset clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// rv32m_multiply_divide
// Pipelined RV32M multiply and divide unit with pass-through tag.
// ----------------------------------------------------------------------------
`include "rv32m_multiply_divide_defines.svh"

module rv32m_multiply_divide #(
    parameter int TagBits = rvm_pkg::TAG_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // operand_a [31:0], operand_b [63:32], tag, zero fill
    input  logic [((2*rvm_pkg::DATA_BITS+TagBits+7)/8)*8-1:0] s_tdata,
    // operation [2:0]
    input  logic [rvm_pkg::OP_BITS-1:0]             s_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // result [31:0], result_tag, zero fill
    output logic [((rvm_pkg::DATA_BITS+TagBits+7)/8)*8-1:0] m_tdata
);

    localparam int W      = rvm_pkg::DATA_BITS;
    localparam int OUT_W  = ((W + TagBits + 7) / 8) * 8;
    localparam int STEPS  = W;

    logic               vld [0:STEPS];
    logic               rdy [0:STEPS];
    rvm_pkg::stage_t    dat [0:STEPS];
    logic [TagBits-1:0] tg  [0:STEPS];
    logic [W-1:0]       result;
    logic [TagBits-1:0] result_tag;

    rvm_pre #(.TagBits(TagBits)) u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tuser),
        .in_a      (s_tdata[W-1:0]),
        .in_b      (s_tdata[2*W-1:W]),
        .in_tag    (s_tdata[2*W +: TagBits]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_data  (dat[0]),
        .out_tag   (tg[0])
    );

    for (genvar k = 1; k <= STEPS; k++)
    begin : g_step
        rvm_stage #(.Idx(k), .TagBits(TagBits)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[k-1]),
            .in_ready  (rdy[k-1]),
            .in_data   (dat[k-1]),
            .in_tag    (tg[k-1]),
            .out_valid (vld[k]),
            .out_ready (rdy[k]),
            .out_data  (dat[k]),
            .out_tag   (tg[k])
        );
    end

    rvm_post #(.TagBits(TagBits)) u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vld[STEPS]),
        .in_ready   (rdy[STEPS]),
        .in_data    (dat[STEPS]),
        .in_tag     (tg[STEPS]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result),
        .out_tag    (result_tag)
    );

    assign m_tdata = OUT_W'({result_tag, result});

    `RVM_ASSERT(a_empty_out_ready, !m_tvalid |-> s_tready, "pipeline blocked with empty output")
    `RVM_ASSERT(a_accept_fills, s_tvalid && s_tready |=> vld[0], "accepted request lost")
    `RVM_ASSERT(a_last_hold, vld[STEPS] && !rdy[STEPS] |=> vld[STEPS] && $stable(dat[STEPS]), "stalled stage changed")
    `RVM_ASSERT_KNOWN(a_out_valid_known, m_tvalid, "output valid unknown")

endmodule
